@@ rtl/alarf_pkg.sv @@
package alarf_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 9;
   localparam int POS_W    = 8;
   localparam int VAL_W    = 32;
   localparam int STAT_W   = 3;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_FIND   = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [1:0]              operation;
      logic signed [VAL_W-1:0] item_value;
      logic [POS_W-1:0]        item_position;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic [POS_W-1:0]        found_index;
      logic signed [VAL_W-1:0] read_value;
      logic [CNT_W-1:0]        entry_count;
   } rsp_type;

endpackage

@@ rtl/array_list_append_remove_find.sv @@
// Dense list of signed 32-bit values held in a 256-entry RAM with one read
// and one write port. Requests arrive on the req_ channel (valid/ready); each
// one gives exactly one result on the rsp_ channel (valid/ready), in request
// order. Every result carries the entry count after the request.
// One request is worked on at a time. Append writes the new value at the
// end of the list; read fetches the entry at its position; find scans from
// entry zero and stops at the first match; remove moves each later entry
// down one place, one per cycle. A request rejected by its checks touches
// no entry. Find and remove visit one entry per cycle through the RAM read
// port; read data is registered and arrives in the cycle after its address.
// The result sits in an output register; the next request is accepted
// while it waits. If the receiver stalls, a finished result is held inside
// until the output register frees, and no new request is taken meanwhile.
// Synchronous reset empties the list (count zero) and drops any pending
// result; RAM contents are not cleared and need not be.
module array_list_append_remove_find (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  alarf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output alarf_pkg::rsp_type rsp_data
);
   import alarf_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_RDWAIT = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [1:0]              op_ff, op_in;
   logic [VAL_W-1:0]        val_ff, val_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        scan_ff, scan_in;
   logic [CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    rdv_ff, rdv_in;
   logic [STAT_W-1:0]       res_status_ff, res_status_in;
   logic [POS_W-1:0]        res_index_ff, res_index_in;
   logic [VAL_W-1:0]        res_value_ff, res_value_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [VAL_W-1:0]        mem [CAPACITY];
   logic [VAL_W-1:0]        rdata_ff;
   logic [ADDR_W-1:0]       mem_ra, mem_wa;
   logic [VAL_W-1:0]        mem_wd;
   logic                    mem_we;
   logic                    scan_more;
   logic [CNT_W-1:0]        down_idx;

   assign scan_more = scan_ff < count_ff;
   assign down_idx  = rd_idx_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[mem_ra];
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      rd_idx_in     = rd_idx_ff;
      rdv_in        = rdv_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      mem_ra        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.operation;
               val_in   = req_data.item_value;
               pos_in   = req_data.item_position;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_index_in = '0;
            res_value_in = '0;
            unique case (op_ff)
               OP_APPEND: begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_we        = 1'b1;
                     mem_wa        = count_ff[ADDR_W-1:0];
                     mem_wd        = val_ff;
                     count_in      = count_ff + CNT_W'(1);
                     res_status_in = ST_OK;
                  end
                  state_in = S_EMIT;
               end
               OP_FIND: begin
                  scan_in  = '0;
                  rdv_in   = 1'b0;
                  state_in = S_SCAN;
               end
               OP_REMOVE, OP_READ: begin
                  priority if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_EMIT;
                  end else if (CNT_W'(pos_ff) >= count_ff) begin
                     res_status_in = ST_BAD_POS;
                     state_in      = S_EMIT;
                  end else if (op_ff == OP_READ) begin
                     mem_ra   = ADDR_W'(pos_ff);
                     state_in = S_RDWAIT;
                  end else begin
                     scan_in  = CNT_W'(pos_ff) + CNT_W'(1);
                     rdv_in   = 1'b0;
                     state_in = S_SCAN;
                  end
               end
            endcase
         end
         S_SCAN: begin
            if (op_ff == OP_FIND) begin
               priority if (rdv_ff && rdata_ff == val_ff) begin
                  res_status_in = ST_OK;
                  res_index_in  = rd_idx_ff[POS_W-1:0];
                  rdv_in        = 1'b0;
                  state_in      = S_EMIT;
               end else if (scan_more) begin
                  mem_ra    = scan_ff[ADDR_W-1:0];
                  rdv_in    = 1'b1;
                  rd_idx_in = scan_ff;
                  scan_in   = scan_ff + CNT_W'(1);
               end else begin
                  res_status_in = ST_NOT_FOUND;
                  rdv_in        = 1'b0;
                  state_in      = S_EMIT;
               end
            end else begin
               // shift down: entry read last cycle goes one place lower
               if (rdv_ff) begin
                  mem_we = 1'b1;
                  mem_wa = down_idx[ADDR_W-1:0];
                  mem_wd = rdata_ff;
               end
               if (scan_more) begin
                  mem_ra    = scan_ff[ADDR_W-1:0];
                  rdv_in    = 1'b1;
                  rd_idx_in = scan_ff;
                  scan_in   = scan_ff + CNT_W'(1);
               end else begin
                  count_in      = count_ff - CNT_W'(1);
                  res_status_in = ST_OK;
                  rdv_in        = 1'b0;
                  state_in      = S_EMIT;
               end
            end
         end
         S_RDWAIT: begin
            res_status_in = ST_OK;
            res_value_in  = rdata_ff;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = res_status_ff;
               rsp_data_in.found_index  = res_index_ff;
               rsp_data_in.read_value   = res_value_ff;
               rsp_data_in.entry_count  = count_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_value_ff  <= res_value_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/alarf_checker.sv @@
module alarf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input alarf_pkg::rsp_type rsp_data
);
   import alarf_pkg::*;

   // one request in flight: busy straight after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.entry_count == CNT_W'(CAPACITY))
      else $error("full reported below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.entry_count == '0)
      else $error("empty reported with entries present");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK
      |-> rsp_data.found_index == '0 && rsp_data.read_value == '0)
      else $error("failed request carries data");

endmodule

bind array_list_append_remove_find alarf_checker u_alarf_checker (.*);
